[rtl/smt_pkg.sv]
// ----------------------------------------------------------------------------
// smt_pkg
// Shared types and constants for the softmax-with-temperature core.
// ----------------------------------------------------------------------------
package smt_pkg;

    localparam int SMT_MAX_LEN = 64;
    localparam int SMT_CNT_W   = 7;   // holds a count up to 64
    localparam int SMT_IDX_W   = 6;   // element_index field width

    localparam logic [15:0] SMT_INVT_RESET = 16'd4096;
    localparam logic [20:0] SMT_K_LIMIT    = 21'd4096;  // k above this: e = 0
    localparam logic        SMT_REG_INVT   = 1'b0;      // register index of inverse_temperature

    typedef struct packed {
        logic signed [15:0] score;
        logic               last_element;
    } t_in;

    typedef struct packed {
        logic [15:0]          probability;
        logic [SMT_IDX_W-1:0] element_index;
        logic                 last_result;
        logic                 overflowed;
    } t_out;

    // one finished vector handed from front to back
    typedef struct packed {
        logic [SMT_CNT_W-1:0] count;
        logic signed [15:0]   max;
        logic                 ovf;
    } t_job;

endpackage

[rtl/smt_ram.sv]
// ----------------------------------------------------------------------------
// smt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/smt_div.sv]
// ----------------------------------------------------------------------------
// smt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smt_div #(
    parameter int WN = 32,
    parameter int WD = 22,
    localparam int CW = $clog2(WN + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [WN-1:0] i_num,
    input  logic [WD-1:0] i_den,
    output logic          o_done,
    output logic [WN-1:0] o_quot
);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [WN-1:0] r_num;
    logic [WD-1:0] r_den;
    logic [WD-1:0] r_rem;

    logic [WD:0]   trial;
    logic [WD:0]   diff;
    logic          ge;
    logic [WD-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_num[WN-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[WD-1:0] : trial[WD-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(WN);
            end else if (r_busy) begin
                r_num <= {r_num[WN-2:0], ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

[rtl/smt_exp.sv]
// ----------------------------------------------------------------------------
// smt_exp
// Iterative exp(-k/256) in Q0.16: Taylor series of exp(-k/65536) in Q62,
// then eight squarings. Shared 32x32 multiplier, one partial product a cycle.
// ----------------------------------------------------------------------------
module smt_exp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [12:0] i_k,
    output logic        o_done,
    output logic [15:0] o_e
);

    localparam logic [63:0]  Q_ONE   = 64'h4000_0000_0000_0000;
    localparam logic [127:0] RND_61  = 128'h1 << 61;
    localparam logic [63:0]  RND_45  = 64'h1 << 45;
    localparam logic [4:0]   N_LAST  = 5'd16;
    localparam logic [3:0]   SQ_LAST = 4'd7;

    typedef enum logic [2:0] {E_IDLE, E_MUL, E_RES, E_DIV, E_OUT} t_state;

    t_state        r_state;
    logic [63:0]   r_z, r_sum, r_term;
    logic [63:0]   r_ma, r_mb;
    logic [63:0]   r_pp;
    logic [127:0]  r_acc;
    logic [2:0]    r_cnt;
    logic [4:0]    r_n;
    logic [3:0]    r_sq;
    logic          r_sqph;
    logic          r_done;
    logic [15:0]   r_e;

    logic [31:0]   a_part, b_part;
    logic [127:0]  pp_sh;
    logic [127:0]  rnd;
    logic [63:0]   res;
    logic          div_start, div_done;
    logic [63:0]   quot;
    logic [63:0]   n_sum;
    logic [63:0]   out_rnd;
    logic [17:0]   out_val;

    always_comb begin
        a_part = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        b_part = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        case (r_cnt)
            3'd1:    pp_sh = {64'b0, r_pp};
            3'd2:    pp_sh = {32'b0, r_pp, 32'b0};
            3'd3:    pp_sh = {32'b0, r_pp, 32'b0};
            3'd4:    pp_sh = {r_pp, 64'b0};
            default: pp_sh = '0;
        endcase
        rnd       = r_acc + RND_61;
        res       = rnd[125:62];
        div_start = (r_state == E_RES) && !r_sqph;
        n_sum     = r_n[0] ? (r_sum - quot) : (r_sum + quot);
        out_rnd   = r_sum + RND_45;
        out_val   = out_rnd[63:46];
    end

    smt_div #(.WN(64), .WD(5)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (res),
        .i_den   (r_n),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_z     <= 64'(i_k) << 46;
                        r_sum   <= Q_ONE;
                        r_term  <= Q_ONE;
                        r_n     <= 5'd1;
                        r_sqph  <= 1'b0;
                        r_ma    <= Q_ONE;
                        r_mb    <= 64'(i_k) << 46;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= E_MUL;
                    end
                end
                E_MUL: begin
                    if (r_cnt != 3'd4) begin
                        r_pp <= 64'(a_part) * 64'(b_part);
                    end
                    if (r_cnt != 3'd0) begin
                        r_acc <= r_acc + pp_sh;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 3'd4) begin
                        r_state <= E_RES;
                    end
                end
                E_RES: begin
                    if (!r_sqph) begin
                        r_state <= E_DIV;
                    end else begin
                        r_sum <= res;
                        if (r_sq == SQ_LAST) begin
                            r_state <= E_OUT;
                        end else begin
                            r_sq    <= r_sq + 1'b1;
                            r_ma    <= res;
                            r_mb    <= res;
                            r_acc   <= '0;
                            r_cnt   <= '0;
                            r_state <= E_MUL;
                        end
                    end
                end
                E_DIV: begin
                    if (div_done) begin
                        r_term <= quot;
                        r_sum  <= n_sum;
                        r_acc  <= '0;
                        r_cnt  <= '0;
                        r_state <= E_MUL;
                        if (r_n == N_LAST) begin
                            r_sqph <= 1'b1;
                            r_sq   <= '0;
                            r_ma   <= n_sum;
                            r_mb   <= n_sum;
                        end else begin
                            r_n  <= r_n + 1'b1;
                            r_ma <= quot;
                            r_mb <= r_z;
                        end
                    end
                end
                E_OUT: begin
                    r_e     <= (out_val > 18'd65535) ? 16'hFFFF : out_val[15:0];
                    r_done  <= 1'b1;
                    r_state <= E_IDLE;
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_e    = r_e;

endmodule

[rtl/smt_front.sv]
// ----------------------------------------------------------------------------
// smt_front
// Input side: stores scores, tracks max, count and overflow, and queues
// one job per finished vector for the back end.
// ----------------------------------------------------------------------------
module smt_front
    import smt_pkg::*;
#(
    parameter int MAX_LEN = SMT_MAX_LEN,
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int CW = $clog2(MAX_LEN + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  t_in           i_item,
    input  logic          i_pop,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [15:0]   o_wdata,
    output t_job          o_job,
    output logic          o_job_valid
);

    logic signed [15:0] r_max;
    logic [CW-1:0]      r_count;
    logic               r_ovf;
    t_job               r_q [2];
    logic [1:0]         r_q_cnt;

    logic               room;
    logic signed [15:0] n_max;
    logic [CW-1:0]      n_count;
    logic               n_ovf;
    logic               push;
    t_job               job_new;

    always_comb begin
        room    = (r_count < CW'(MAX_LEN));
        n_max   = r_max;
        n_count = r_count;
        n_ovf   = r_ovf;
        if (room) begin
            if (i_item.score > r_max) begin
                n_max = i_item.score;
            end
            n_count = r_count + 1'b1;
        end else begin
            n_ovf = 1'b1;
        end
        push          = i_acc && i_item.last_element;
        job_new.count = SMT_CNT_W'(n_count);
        job_new.max   = n_max;
        job_new.ovf   = n_ovf;
    end

    assign o_we        = i_acc && room;
    assign o_waddr     = r_count[AW-1:0];
    assign o_wdata     = i_item.score;
    assign o_job       = r_q[0];
    assign o_job_valid = (r_q_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= -16'sd32768;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_q_cnt <= '0;
        end else begin
            if (i_acc) begin
                if (i_item.last_element) begin
                    r_max   <= -16'sd32768;
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_max   <= n_max;
                    r_count <= n_count;
                    r_ovf   <= n_ovf;
                end
            end
            // two-deep job queue, head at entry 0
            if (i_pop && o_job_valid) begin
                if (push) begin
                    if (r_q_cnt[1]) begin
                        r_q[0] <= r_q[1];
                        r_q[1] <= job_new;
                    end else begin
                        r_q[0] <= job_new;
                    end
                end else begin
                    r_q[0]  <= r_q[1];
                    r_q_cnt <= r_q_cnt - 1'b1;
                end
            end else if (push && r_q_cnt != 2'd2) begin
                r_q[r_q_cnt[0]] <= job_new;
                r_q_cnt         <= r_q_cnt + 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LEN))
        else $error("element count beyond store size");

endmodule

[rtl/smt_back.sv]
// ----------------------------------------------------------------------------
// smt_back
// Execution side: exp pass over the stored scores, then divide pass that
// emits one probability per element.
// ----------------------------------------------------------------------------
module smt_back
    import smt_pkg::*;
#(
    parameter int MAX_LEN = SMT_MAX_LEN,
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int SW = $clog2(MAX_LEN * 65535 + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_invt,
    input  t_job          i_job,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    output logic [AW-1:0] o_sraddr,
    input  logic [15:0]   i_srdata,
    output logic          o_strobe,
    output t_out          o_result,
    output logic          o_active
);

    typedef enum logic [3:0] {
        B_IDLE, B_RD, B_MUL, B_K, B_EXP, B_WR, B_RD2, B_DIV, B_DWAIT
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_last;
    logic signed [15:0] r_max;
    logic               r_ovf;
    logic [31:0]        r_m;
    logic [15:0]        r_e;
    logic [SW-1:0]      r_sum;
    logic               r_strobe;
    t_out               r_out;

    logic [16:0] diff;
    logic [32:0] m_rnd;
    logic [20:0] k;
    logic        exp_start, exp_done;
    logic [15:0] exp_e;
    logic [15:0] erd;
    logic        div_start, div_done;
    logic [31:0] quot;

    always_comb begin
        diff      = {r_max[15], r_max} - {i_srdata[15], i_srdata};
        m_rnd     = {1'b0, r_m} + 33'd2048;
        k         = m_rnd[32:12];
        exp_start = (r_state == B_K) && (k <= SMT_K_LIMIT);
        div_start = (r_state == B_DIV);
    end

    assign o_job_pop = (r_state == B_IDLE) && i_job_valid;
    assign o_sraddr  = r_idx;
    assign o_strobe  = r_strobe;
    assign o_result  = r_out;
    assign o_active  = (r_state != B_IDLE) || r_strobe;

    smt_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (exp_start),
        .i_k     (k[12:0]),
        .o_done  (exp_done),
        .o_e     (exp_e)
    );

    smt_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == B_WR),
        .i_waddr (r_idx),
        .i_wdata (r_e),
        .i_raddr (r_idx),
        .o_rdata (erd)
    );

    smt_div #(.WN(32), .WD(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({erd, 16'b0}),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_idx   <= '0;
                        r_last  <= AW'(i_job.count - 1'b1);
                        r_max   <= i_job.max;
                        r_ovf   <= i_job.ovf;
                        r_sum   <= '0;
                        r_state <= B_RD;
                    end
                end
                B_RD:  r_state <= B_MUL;      // score read in flight
                B_MUL: begin
                    r_m     <= 32'(diff[15:0]) * 32'(i_invt);
                    r_state <= B_K;
                end
                B_K: begin
                    if (k > SMT_K_LIMIT) begin
                        r_e     <= '0;
                        r_state <= B_WR;
                    end else begin
                        r_state <= B_EXP;
                    end
                end
                B_EXP: begin
                    if (exp_done) begin
                        r_e     <= exp_e;
                        r_state <= B_WR;
                    end
                end
                B_WR: begin
                    r_sum <= r_sum + SW'(r_e);
                    if (r_idx == r_last) begin
                        r_idx   <= '0;
                        r_state <= B_RD2;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= B_RD;
                    end
                end
                B_RD2: r_state <= B_DIV;      // exp read in flight
                B_DIV: r_state <= B_DWAIT;
                B_DWAIT: begin
                    if (div_done) begin
                        r_strobe                <= 1'b1;
                        r_out.probability       <= (quot > 32'd65535) ? 16'hFFFF : quot[15:0];
                        r_out.element_index     <= SMT_IDX_W'(r_idx);
                        r_out.last_result       <= (r_idx == r_last);
                        r_out.overflowed        <= r_ovf;
                        if (r_idx == r_last) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= B_RD2;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.last_result) |-> (r_state == B_IDLE))
        else $error("last word shown while pass still running");

    a_sum_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_sum != '0))
        else $error("divide pass started with zero sum");

endmodule

[rtl/softmax_with_temperature_core.sv]
// ----------------------------------------------------------------------------
// softmax_with_temperature_core
// Streaming softmax with temperature over signed Q7.8 score vectors.
// ----------------------------------------------------------------------------
// Input: one word per cycle while filling a vector (busy low).
// After the last word, the exp pass runs each element through the iterative
//   exp unit (16 series terms, each a multiply, a result step and a divide,
//   then eight squarings), or gives 0 where (score - max) times inverse
//   temperature is below -16; then the divide pass (32-bit restoring divider)
//   gives one result per element. busy stays high until the last result has been strobed.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset is synchronous, active low; the score and exp stores need no clearing.
module softmax_with_temperature_core
    import smt_pkg::*;
#(
    parameter int MAX_LEN = SMT_MAX_LEN,
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        start,
    output logic        busy,
    input  t_in         i_item,
    // result channel
    output logic        o_strobe,
    output t_out        o_result,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]   r_invt;     // inverse temperature, Q4.12

    logic          acc;
    logic          sc_we;
    logic [AW-1:0] sc_waddr, sc_raddr;
    logic [15:0]   sc_wdata, sc_rdata;
    t_job          job;
    logic          job_valid, job_pop;
    logic          back_active;
    logic          reg_hit;

    // one vector in flight at a time: the store is reread by the back end
    assign busy   = job_valid || back_active;
    assign acc    = start && !busy;

    // config: single register at words 0 to 3 (only paddr[2] is decoded)
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == SMT_REG_INVT);
    assign prdata  = reg_hit ? {16'b0, r_invt} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invt <= SMT_INVT_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_invt <= pwdata[15:0];
        end
    end

    smt_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_item      (i_item),
        .i_pop       (job_pop),
        .o_we        (sc_we),
        .o_waddr     (sc_waddr),
        .o_wdata     (sc_wdata),
        .o_job       (job),
        .o_job_valid (job_valid)
    );

    // score store: written by the front, read by the back
    smt_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (sc_we),
        .i_waddr (sc_waddr),
        .i_wdata (sc_wdata),
        .i_raddr (sc_raddr),
        .o_rdata (sc_rdata)
    );

    smt_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_invt      (r_invt),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .o_sraddr    (sc_raddr),
        .i_srdata    (sc_rdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .o_active    (back_active)
    );

    a_no_store_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sc_we |-> !back_active)
        else $error("score store written while back end reads it");

endmodule

[verif/softmax_prob_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// softmax_prob_checker
// Watches the word, result and register channels of the softmax core, works
// out the probabilities each vector should give and compares them in order.
// ----------------------------------------------------------------------------
module softmax_prob_checker
    import smt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_in         i_item,
    input  logic        i_strobe,
    input  t_out        i_result,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    logic signed [15:0] scores [SMT_MAX_LEN];
    logic signed [15:0] vec_max;
    int                 vec_len;
    logic               vec_ovf;
    logic [15:0]        inv_temp;
    t_out               prob_queue [$];

    // (a * b) >> 62, rounded
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << 61);
        return p[125:62];
    endfunction

    // rounded Q0.16 value of exp(-k/256), k in 0..4096
    function automatic logic [15:0] exp_neg_q16(input logic [63:0] k);
        logic [63:0] z, acc, term, r;
        z    = k << 46;
        acc  = 64'd1 << 62;
        term = 64'd1 << 62;
        for (int n = 1; n <= 16; n++) begin
            term = q62_mul(term, z) / n;
            if (n % 2 == 1) acc = acc - term;
            else            acc = acc + term;
        end
        for (int n = 0; n < 8; n++) acc = q62_mul(acc, acc);
        r = (acc + (64'd1 << 45)) >> 46;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    task automatic predict_vector();
        logic [15:0] e [SMT_MAX_LEN];
        logic [63:0] diff, m, k, total, p;
        t_out        res;
        total = 0;
        for (int i = 0; i < vec_len; i++) begin
            diff = 64'(unsigned'(17'(vec_max - scores[i])));
            m    = diff * inv_temp;
            k    = (m + 64'd2048) >> 12;
            e[i] = (k > 64'(SMT_K_LIMIT)) ? 16'd0 : exp_neg_q16(k);
            total += e[i];
        end
        for (int i = 0; i < vec_len; i++) begin
            p = ({48'd0, e[i]} << 16) / total;
            res.probability   = (p > 64'd65535) ? 16'hFFFF : p[15:0];
            res.element_index = SMT_IDX_W'(i);
            res.last_result   = (i + 1 == vec_len);
            res.overflowed    = vec_ovf;
            prob_queue.push_back(res);
        end
    endtask

    task automatic note_fail(input string what);
        o_fail_count++;
        if (o_fail_count <= 10) $display("%t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            vec_max      = -16'sd32768;
            vec_len      = 0;
            vec_ovf      = 1'b0;
            inv_temp     = SMT_INVT_RESET;
            o_fail_count = 0;
            prob_queue.delete();
        end else begin
            // register port: writes update our copy, reads of register 0 are checked
            if (i_psel && i_penable && i_pready) begin
                if (i_paddr[2] == SMT_REG_INVT && i_paddr[1:0] == 2'd0) begin
                    if (i_pwrite)
                        inv_temp = i_pwdata[15:0];
                    else if (i_prdata[15:0] !== inv_temp)
                        note_fail($sformatf("register read: expected %0d got %0d",
                                            inv_temp, i_prdata[15:0]));
                end
            end
            if (i_strobe) begin
                if (prob_queue.size() == 0) begin
                    note_fail($sformatf("unexpected result %p", i_result));
                end else begin
                    want = prob_queue.pop_front();
                    if (i_result !== want)
                        note_fail($sformatf("result: expected %p got %p", want, i_result));
                end
            end
            // word accepted
            if (i_start && !i_busy) begin
                if (vec_len < SMT_MAX_LEN) begin
                    scores[vec_len] = i_item.score;
                    if (vec_len == 0 || i_item.score > vec_max) vec_max = i_item.score;
                    vec_len++;
                end else begin
                    vec_ovf = 1'b1;
                end
                if (i_item.last_element) begin
                    predict_vector();
                    vec_len = 0;
                    vec_ovf = 1'b0;
                    vec_max = -16'sd32768;
                end
            end
        end
        o_pending = prob_queue.size();
    end

endmodule

[verif/tb_softmax_with_temperature_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_softmax_with_temperature_core
// Drives score vectors and temperature settings into the softmax core; the
// checker beside it predicts and compares every probability word.
// ----------------------------------------------------------------------------
module tb_softmax_with_temperature_core;
    import smt_pkg::*;

    // generous: well beyond what a full 64-element vector costs
    localparam int CYCLE_LIMIT = 3_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_item;
    logic        o_strobe;
    t_out        o_result;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending;
    int          cycles = 0;
    int          gap_pct;   // chance in a hundred of an idle gap before a word

    softmax_with_temperature_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    softmax_prob_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_softmax_with_temperature_core: FAIL");
            $finish;
        end
    end

    // Every task starts and ends on a rising edge. A word task leaves start
    // high so back-to-back words go out without a dip; whatever follows a
    // word drives start exactly once in that time step.
    task automatic send_word(input logic signed [15:0] s, input logic last);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{score: s, last_element: last};
        // busy only moves on a rising edge, so sample it mid-cycle
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // quiet the word channel and let the core drain every pending word
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (busy || pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write inverse temperature, then read it back through the checker
    task automatic set_inv_temp(input logic [15:0] v);
        wait_drained();
        reg_access(1'b1, 3'd0, {$urandom} & 32'hFFFF_0000 | 32'(v));
        reg_access(1'b0, 3'd0, 32'd0);
    endtask

    task automatic send_vector(input int len);
        logic signed [15:0] base, s;
        int                 mode;
        mode = $urandom_range(3);
        base = 16'($urandom);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0:       s = 16'($urandom);                                // full range
                1:       s = base + $signed(16'($urandom_range(0, 2047)) - 16'sd1024);
                2:       s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000; // extremes
                default: s = base + $signed(16'($urandom_range(0, 15)) - 16'sd8);
            endcase
            send_word(s, i == len - 1);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 8);
        if (r < 90) return $urandom_range(9, 40);
        if (r < 95) return SMT_MAX_LEN;
        return $urandom_range(SMT_MAX_LEN + 1, SMT_MAX_LEN + 6);  // store overflow
    endfunction

    function automatic logic [15:0] pick_inv_temp();
        case ($urandom_range(5))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return SMT_INVT_RESET;
            3:       return 16'd0;
            4:       return 16'($urandom_range(256, 8192));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int sent;
        gap_pct = 0;
        start   = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset temperature first, then the corners
        send_word(16'sh8000, 1'b1);                 // lone most-negative score
        send_word(16'sh7FFF, 1'b0);                 // widest spread
        send_word(16'sh8000, 1'b0);
        send_word(16'sd100, 1'b1);
        send_word(16'sd5, 1'b0);                    // equal scores: uniform
        send_word(16'sd5, 1'b0);
        send_word(16'sd5, 1'b1);
        set_inv_temp(16'hFFFF);                     // largest inverse temperature: sharpest scaling
        send_word(-16'sd1, 1'b0);
        send_word(16'sh00FF, 1'b0);
        send_word(-16'sd256, 1'b1);
        set_inv_temp(16'd0);                        // zero: uniform whatever the scores
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b1);
        set_inv_temp(16'd1);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b1);
        wait_drained();
        reg_access(1'b1, 3'd4, 32'd12345);          // unmapped register: no effect
        set_inv_temp(SMT_INVT_RESET);
        send_word(16'sd0, 1'b0);
        send_word(16'sd4096, 1'b1);                 // d just at the exp cut-off

        // random: sender mostly busy, then often idle, then flat out
        for (int ph = 0; ph < 3; ph++) begin
            gap_pct = (ph == 0) ? 7 : (ph == 1) ? 55 : 0;
            set_inv_temp(pick_inv_temp());
            sent = 0;
            while (sent < 100) begin
                int len;
                if ($urandom_range(7) == 0) set_inv_temp(pick_inv_temp());
                len = pick_len();
                send_vector(len);
                sent += len;
            end
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_softmax_with_temperature_core: PASS");
        end else begin
            $display("tb_softmax_with_temperature_core: FAIL");
        end
        $finish;
    end

endmodule
